/* src/gbc_pkg.sv */
// ----------------------------------------------------------------------------
// gbc_pkg: shared types and constants of the GOST block cipher
// Stage record, key array type, S-box table, round function and key order.
// ----------------------------------------------------------------------------
package gbc_pkg;

   localparam int unsigned NUM_ROUNDS = 32;
   localparam int unsigned NUM_KEYS   = 8;
   localparam int unsigned KEY_IDX_W  = 3;
   localparam int unsigned CSR_IDX_W  = 4;

   typedef logic [NUM_KEYS-1:0][31:0] key_array_type;

   // One stage of the round chain: control plus the two halves
   typedef struct packed {
      logic        valid;
      logic        dir;
      logic [31:0] left;
      logic [31:0] right;
   } stage_type;

   // Key register values after reset, word 0 in the lowest slot
   localparam key_array_type KEY_RESET = {
      32'd3703418914, 32'd2854371254, 32'd2227323641, 32'd2920459799,
      32'd1124710742, 32'd2804780101, 32'd1620462276, 32'd0
   };

   // S-box, row i serves nibble i (nibble 0 least significant)
   localparam logic [3:0] SBOX [8][16] = '{
      '{4'd13, 4'd2,  4'd8,  4'd4,  4'd6,  4'd15, 4'd11, 4'd1,
        4'd10, 4'd9,  4'd3,  4'd14, 4'd5,  4'd0,  4'd12, 4'd7},
      '{4'd4,  4'd11, 4'd2,  4'd14, 4'd15, 4'd0,  4'd8,  4'd13,
        4'd3,  4'd12, 4'd9,  4'd7,  4'd5,  4'd10, 4'd6,  4'd1},
      '{4'd12, 4'd1,  4'd10, 4'd15, 4'd9,  4'd2,  4'd6,  4'd8,
        4'd0,  4'd13, 4'd3,  4'd4,  4'd14, 4'd7,  4'd5,  4'd11},
      '{4'd2,  4'd12, 4'd4,  4'd1,  4'd7,  4'd10, 4'd11, 4'd6,
        4'd8,  4'd5,  4'd3,  4'd15, 4'd13, 4'd0,  4'd14, 4'd9},
      '{4'd7,  4'd13, 4'd14, 4'd3,  4'd0,  4'd6,  4'd9,  4'd10,
        4'd1,  4'd2,  4'd8,  4'd5,  4'd11, 4'd12, 4'd4,  4'd15},
      '{4'd10, 4'd0,  4'd9,  4'd14, 4'd6,  4'd3,  4'd15, 4'd5,
        4'd1,  4'd13, 4'd12, 4'd7,  4'd11, 4'd4,  4'd2,  4'd8},
      '{4'd15, 4'd1,  4'd8,  4'd14, 4'd6,  4'd11, 4'd3,  4'd4,
        4'd9,  4'd7,  4'd2,  4'd13, 4'd12, 4'd0,  4'd5,  4'd10},
      '{4'd14, 4'd4,  4'd13, 4'd1,  4'd2,  4'd15, 4'd11, 4'd8,
        4'd3,  4'd10, 4'd6,  4'd12, 4'd5,  4'd9,  4'd0,  4'd7}
   };

   // Key word used in a round; dir 0 encrypts, 1 decrypts
   function automatic logic [KEY_IDX_W-1:0] key_index(input logic dir,
                                                      input int unsigned rnd);
      logic [KEY_IDX_W-1:0] pos;
      logic [1:0]           pass;
      logic                 fwd;
      pos  = KEY_IDX_W'(rnd % NUM_KEYS);
      pass = 2'((rnd / NUM_KEYS) % 4);
      fwd  = dir ? (pass == 2'd0) : (pass != 2'd3);
      return fwd ? pos : KEY_IDX_W'(NUM_KEYS - 1) - pos;
   endfunction

   // Key addition modulo 2^32, nibble substitution, then rotate left by 11
   function automatic logic [31:0] round_func(input logic [31:0] half,
                                              input logic [31:0] key);
      logic [31:0] sum;
      logic [31:0] subst;
      sum = half + key;
      for (int i = 0; i < 8; i++) begin
         subst[4*i +: 4] = SBOX[i][sum[4*i +: 4]];
      end
      return {subst[20:0], subst[31:21]};
   endfunction

endpackage

/* src/gbc_round_cell.sv */
// ----------------------------------------------------------------------------
// gbc_round_cell: one Feistel round of the cipher chain
// Registers the halves after its round and hands them to the next cell.
// ----------------------------------------------------------------------------
module gbc_round_cell #(
   parameter int unsigned ROUND_IDX = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  gbc_pkg::key_array_type key_words,
   input  gbc_pkg::stage_type    stage_in,
   output gbc_pkg::stage_type    stage_out
);
   import gbc_pkg::*;

   localparam logic [KEY_IDX_W-1:0] ENC_IDX = key_index(1'b0, ROUND_IDX);
   localparam logic [KEY_IDX_W-1:0] DEC_IDX = key_index(1'b1, ROUND_IDX);

   stage_type   stage_ff;
   stage_type   stage_next_in;
   logic [31:0] round_key;

   // Pick this round's key word for the transaction's direction
   assign round_key = stage_in.dir ? key_words[DEC_IDX] : key_words[ENC_IDX];

   // Compute the round and swap the halves
   always_comb begin
      stage_next_in.valid = stage_in.valid;
      stage_next_in.dir   = stage_in.dir;
      stage_next_in.left  = stage_in.right;
      stage_next_in.right = stage_in.left ^ round_func(stage_in.right, round_key);
   end

   // Advance control and payload
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (advance) begin
         stage_ff.valid <= stage_next_in.valid;
      end
      if (advance) begin
         stage_ff.dir   <= stage_next_in.dir;
         stage_ff.left  <= stage_next_in.left;
         stage_ff.right <= stage_next_in.right;
      end
   end

   assign stage_out = stage_ff;

endmodule

/* src/gbc_out_skid.sv */
// ----------------------------------------------------------------------------
// gbc_out_skid: output register with a skid entry
// Catches the last cell's result while the receiver stalls the output.
// ----------------------------------------------------------------------------
module gbc_out_skid (
   input  logic               clock,
   input  logic               reset,
   input  gbc_pkg::stage_type last_stage,
   output logic               advance,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [63:0]        rsp_block_out
);
   import gbc_pkg::*;

   logic        out_valid_ff;
   logic        out_valid_in;
   logic [63:0] out_data_ff;
   logic [63:0] out_data_in;
   logic        skid_valid_ff;
   logic        skid_valid_in;
   logic [63:0] skid_data_ff;
   logic [63:0] skid_data_in;
   logic        incoming;
   logic        out_take;
   logic [63:0] last_block;

   assign advance    = !skid_valid_ff;
   assign incoming   = advance && last_stage.valid;
   assign out_take   = out_valid_ff && !rsp_stall;
   assign last_block = {last_stage.right, last_stage.left};

   // Steer the result into the output register or the skid entry
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (out_take) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (!out_valid_ff || out_take) begin
         out_valid_in = incoming;
         out_data_in  = last_block;
      end else if (incoming) begin
         skid_valid_in = 1'b1;
         skid_data_in  = last_block;
      end
   end

   // Hold control
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // Hold payload
   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_block_out = out_data_ff;

endmodule

/* src/gost_block_cipher.sv */
// An accepted request passes through the registers of the 32 round cells and
// then the output register before it shows on rsp_valid.
// Throughput: one block per cycle through the 32-cell round chain.
// The chain and input hold only while the skid entry at the output is full.
// Reset (synchronous, active high) empties the chain and output and loads
// the key registers with their default words.
// ----------------------------------------------------------------------------
// gost_block_cipher: GOST 28147-89 block cipher, codebook mode
// Key registers, a chain of 32 round cells and an output register with skid.
// ----------------------------------------------------------------------------
module gost_block_cipher (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [63:0]                    req_block_in,
   input  logic                           req_command,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [63:0]                    rsp_block_out,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [gbc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [31:0]                    csr_data
);
   import gbc_pkg::*;

   key_array_type key_ff;
   stage_type     stages [NUM_ROUNDS+1];
   logic          advance;

   assign csr_ready = 1'b1;

   // Write key words; drop writes past the last register
   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= KEY_RESET;
      end else if (csr_valid && csr_ready && (csr_index < CSR_IDX_W'(NUM_KEYS))) begin
         key_ff[csr_index[KEY_IDX_W-1:0]] <= csr_data;
      end
   end

   // Feed the first cell with the request transaction
   always_comb begin
      stages[0].valid = req_valid;
      stages[0].dir   = req_command;
      stages[0].left  = req_block_in[63:32];
      stages[0].right = req_block_in[31:0];
   end

   // Round chain
   for (genvar r = 0; r < NUM_ROUNDS; r++) begin : g_round
      gbc_round_cell #(
         .ROUND_IDX (r)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .key_words (key_ff),
         .stage_in  (stages[r]),
         .stage_out (stages[r+1])
      );
   end

   gbc_out_skid u_out (
      .clock         (clock),
      .reset         (reset),
      .last_stage    (stages[NUM_ROUNDS]),
      .advance       (advance),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_block_out (rsp_block_out)
   );

   assign req_stall = !advance;

endmodule

/* src/gbc_checker.sv */
// ----------------------------------------------------------------------------
// gbc_checker: port-level checks of the GOST block cipher
// Watches the result and request handshakes and the reset behavior.
// ----------------------------------------------------------------------------
module gbc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [63:0] rsp_block_out
);

   // Hold a stalled result transaction
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_block_out))
      else $error("stalled result transaction dropped or changed");

   // Come out of reset with nothing pending
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("result or stall present after reset");

   // Stall the input only while a result is waiting
   a_stall_needs_rsp: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled with no result pending");

   // Raise input stall only after the output was stalled
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(req_stall) |-> $past(rsp_valid && rsp_stall))
      else $error("input stall raised without an output stall");

endmodule

bind gost_block_cipher gbc_checker u_gbc_checker (.*);

/* test/gost_block_cipher_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gost_block_cipher_test: self-checking bench for the GOST block cipher
// Streams blocks in both directions under reset, extreme and random keys.
// Every accepted block is enciphered by an independent predictor, and each
// result is compared in order against it. The sender idles and the receiver
// stalls at random, with one long receiver hold-off that backs up the round chain.
// ----------------------------------------------------------------------------

localparam logic CMD_ENCRYPT = 1'b0;
localparam logic CMD_DECRYPT = 1'b1;

// Predicts the enciphered block for each accepted transaction and holds the
// blocks still owed by the cipher, oldest first.
class cipher_scoreboard;
   bit [31:0]      key_words [gbc_pkg::NUM_KEYS];
   bit [0:15][3:0] sbox_rows [8];
   bit [63:0]      expected_blocks [$];
   int unsigned    mismatches;
   int unsigned    encrypt_count;
   int unsigned    decrypt_count;
   int unsigned    checked_count;

   function new();
      // entry n of a row is the nth nibble from the left
      sbox_rows = '{64'hD2846FB1A93E50C7, 64'h4B2EF08D3C975A61,
                    64'hC1AF92680D34E75B, 64'h2C417AB6853FD0E9,
                    64'h7DE3069A1285BC4F, 64'hA09E63F51DC7B428,
                    64'hF18E6B34972DC05A, 64'hE4D12FB83A6C5907};
      key_words = '{32'd0, 32'd1620462276, 32'd2804780101, 32'd1124710742,
                    32'd2920459799, 32'd2227323641, 32'd2854371254, 32'd3703418914};
      mismatches    = 0;
      encrypt_count = 0;
      decrypt_count = 0;
      checked_count = 0;
   endfunction

   function void write_key(bit [gbc_pkg::CSR_IDX_W-1:0] reg_index, bit [31:0] word);
      // drop writes past the last key word
      if (reg_index < gbc_pkg::NUM_KEYS) begin
         key_words[reg_index] = word;
      end
   endfunction

   // Key word for a round: encrypt walks 0..7 three times then 7..0,
   // decrypt walks 0..7 once then 7..0 three times
   function int unsigned key_slot(bit direction, int unsigned rnd);
      int unsigned position;
      int unsigned pass_no;
      bit          ascending;
      position  = rnd % gbc_pkg::NUM_KEYS;
      pass_no   = rnd / gbc_pkg::NUM_KEYS;
      ascending = (direction == CMD_DECRYPT) ? (pass_no == 0) : (pass_no != 3);
      return ascending ? position : gbc_pkg::NUM_KEYS - 1 - position;
   endfunction

   function bit [31:0] mix_half(bit [31:0] half, bit [31:0] key);
      bit [31:0] sum;
      bit [31:0] subst;
      sum = half + key;
      for (int i = 0; i < 8; i++) begin
         subst[4*i +: 4] = sbox_rows[i][sum[4*i +: 4]];
      end
      return {subst[20:0], subst[31:21]};
   endfunction

   function bit [63:0] encipher_block(bit [63:0] block, bit direction);
      bit [31:0] left_half;
      bit [31:0] right_half;
      bit [31:0] mixed;
      left_half  = block[63:32];
      right_half = block[31:0];
      for (int rnd = 0; rnd < gbc_pkg::NUM_ROUNDS; rnd++) begin
         mixed      = left_half ^ mix_half(right_half, key_words[key_slot(direction, rnd)]);
         left_half  = right_half;
         right_half = mixed;
      end
      return {right_half, left_half};
   endfunction

   function void note_block(logic [63:0] block, logic command);
      expected_blocks.push_back(encipher_block(block, command));
      if (command == CMD_DECRYPT) begin
         decrypt_count++;
      end else begin
         encrypt_count++;
      end
   endfunction

   function void check_block(logic [63:0] actual);
      bit [63:0] expected;
      if (expected_blocks.size() == 0) begin
         mismatches++;
         $display("%0t block_out with nothing owed: expected none, actual %h", $time, actual);
      end else begin
         expected = expected_blocks.pop_front();
         checked_count++;
         if (actual !== expected) begin
            mismatches++;
            $display("%0t block_out mismatch: expected %h, actual %h",
                     $time, expected, actual);
         end
      end
   endfunction

   function int unsigned pending();
      return expected_blocks.size();
   endfunction
endclass

module gost_block_cipher_test;

   localparam int unsigned WATCHDOG_LIMIT   = 4000;
   localparam int unsigned LONG_HOLD_CYCLES = 160;
   localparam int unsigned SETTLE_CYCLES    = 40;
   localparam int unsigned RANDOM_PHASES    = 6;
   localparam int unsigned PHASE_BLOCKS     = 90;
   localparam int unsigned BURST_BLOCKS     = 70;
   localparam int unsigned QUIET_BLOCKS     = 40;
   localparam int unsigned CSR_TOP          = (1 << gbc_pkg::CSR_IDX_W) - 1;
   localparam int unsigned KEYS_ZERO        = 0;
   localparam int unsigned KEYS_ONES        = 1;
   localparam int unsigned KEYS_RANDOM      = 2;

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_stall;
   logic [63:0]                   req_block_in;
   logic                          req_command;
   logic                          rsp_valid;
   logic                          rsp_stall;
   logic [63:0]                   rsp_block_out;
   logic                          csr_valid;
   logic                          csr_ready;
   logic [gbc_pkg::CSR_IDX_W-1:0] csr_index;
   logic [31:0]                   csr_data;

   cipher_scoreboard ledger;
   bit               long_hold_req = 1'b0;
   bit               rsp_quiet     = 1'b0;
   bit               tx_burst      = 1'b0;
   int unsigned      idle_cycles   = 0;
   int unsigned      key_settings  = 1;

   gost_block_cipher u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_block_in  (req_block_in),
      .req_command   (req_command),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_block_out (rsp_block_out),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Observe every handshake on the pre-edge values
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            ledger.note_block(req_block_in, req_command);
         end
         if (rsp_valid && !rsp_stall) begin
            ledger.check_block(rsp_block_out);
         end
         if (csr_valid && csr_ready) begin
            ledger.write_key(csr_index, csr_data);
         end
      end
   end

   // End the run when no transaction moves for too long
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("%0t watchdog: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("TB_ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Mostly short gaps, now and then a long one
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 70) return $urandom_range(1, 2);
      if (roll < 95) return $urandom_range(3, 8);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [31:0] pick_word();
      int unsigned roll;
      roll = $urandom_range(0, 9);
      if (roll == 0) return '0;
      if (roll == 1) return '1;
      return $urandom();
   endfunction

   function automatic logic [63:0] pick_block();
      if ($urandom_range(0, 4) == 0) return {pick_word(), pick_word()};
      return {$urandom(), $urandom()};
   endfunction

   // Receiver: random stalls, quiet stretches and one long hold-off on request
   initial begin
      rsp_stall <= 1'b0;
      @(posedge clock);
      forever begin
         if (long_hold_req) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            long_hold_req = 1'b0;
         end else if (!rsp_quiet && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat (pick_gap()) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
      end
   end

   // Offer one block and hold it until accepted; valid stays up unless a gap follows
   task automatic send_block(input logic [63:0] block, input logic command);
      int unsigned gap;
      req_valid    <= 1'b1;
      req_block_in <= block;
      req_command  <= command;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      gap = (tx_burst || $urandom_range(0, 9) < 6) ? 0 : pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic tx_idle();
      req_valid <= 1'b0;
   endtask

   // Wait until every owed block has come back
   task automatic drain();
      do @(posedge clock); while (ledger.pending() != 0);
   endtask

   task automatic program_key(input logic [gbc_pkg::CSR_IDX_W-1:0] reg_index,
                              input logic [31:0] word);
      csr_valid <= 1'b1;
      csr_index <= reg_index;
      csr_data  <= word;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic csr_idle();
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic load_key_set(input int unsigned style);
      logic [31:0] word;
      for (int k = 0; k < gbc_pkg::NUM_KEYS; k++) begin
         case (style)
            KEYS_ZERO: word = '0;
            KEYS_ONES: word = '1;
            default:   word = pick_word();
         endcase
         program_key(gbc_pkg::CSR_IDX_W'(k), word);
      end
      // an occasional write past the key words must change nothing
      if (style == KEYS_RANDOM && $urandom_range(0, 2) == 0) begin
         program_key(gbc_pkg::CSR_IDX_W'($urandom_range(gbc_pkg::NUM_KEYS, CSR_TOP)),
                     pick_word());
      end
      csr_idle();
      key_settings++;
   endtask

   task automatic send_edge_blocks();
      send_block('0, CMD_ENCRYPT);
      send_block('0, CMD_DECRYPT);
      send_block('1, CMD_ENCRYPT);
      send_block('1, CMD_DECRYPT);
   endtask

   initial begin
      ledger = new();
      reset        <= 1'b1;
      req_valid    <= 1'b0;
      req_block_in <= '0;
      req_command  <= CMD_ENCRYPT;
      csr_valid    <= 1'b0;
      csr_index    <= '0;
      csr_data     <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Default key after reset: extremes and half patterns in both directions
      send_edge_blocks();
      send_block(64'h8000_0000_0000_0000, CMD_ENCRYPT);
      send_block(64'h0000_0000_0000_0001, CMD_DECRYPT);
      send_block(64'h0000_0000_FFFF_FFFF, CMD_ENCRYPT);
      send_block(64'hFFFF_FFFF_0000_0000, CMD_DECRYPT);
      send_block(64'hAAAA_AAAA_5555_5555, CMD_ENCRYPT);
      send_block(64'h5555_5555_AAAA_AAAA, CMD_DECRYPT);
      tx_idle();
      drain();

      // All-zero and all-one keys
      load_key_set(KEYS_ZERO);
      send_edge_blocks();
      tx_idle();
      drain();
      load_key_set(KEYS_ONES);
      send_edge_blocks();
      tx_idle();
      drain();

      // Writes past the key words leave the all-one key in place
      for (int i = gbc_pkg::NUM_KEYS; i <= CSR_TOP; i++) begin
         program_key(gbc_pkg::CSR_IDX_W'(i), $urandom());
      end
      csr_idle();
      send_block('1, CMD_ENCRYPT);
      send_block('0, CMD_DECRYPT);
      tx_idle();
      drain();

      // Random keys and blocks; one phase backs up the chain, one runs unthrottled
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         load_key_set(KEYS_RANDOM);
         if (phase == 1) begin
            long_hold_req = 1'b1;
            tx_burst      = 1'b1;
         end
         if (phase == 3) begin
            rsp_quiet = 1'b1;
            tx_burst  = 1'b1;
         end
         for (int n = 0; n < PHASE_BLOCKS; n++) begin
            if ((phase == 1 && n == BURST_BLOCKS) || (phase == 3 && n == QUIET_BLOCKS)) begin
               rsp_quiet = 1'b0;
               tx_burst  = 1'b0;
            end
            // pause now and then until the chain is empty
            if (n != 0 && $urandom_range(0, 59) == 0) begin
               tx_idle();
               drain();
            end
            send_block(pick_block(), 1'($urandom_range(0, 1)));
         end
         tx_idle();
         drain();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Sent %0d encrypt and %0d decrypt blocks under %0d key settings; %0d checked.",
               ledger.encrypt_count, ledger.decrypt_count, key_settings,
               ledger.checked_count);
      $display("Run included stray register writes, random stalls and a full-chain backup.");
      if (ledger.pending() != 0) begin
         $display("%0t %0d blocks never returned", $time, ledger.pending());
      end
      if (ledger.mismatches == 0 && ledger.pending() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
